// ----- src/sqwg_pkg.sv -----
// Shared types and constants for the quadrature sine/cosine generator.
`timescale 1ns / 1ps

package sqwg_pkg;

  // Configuration port layout
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TURNS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DC_OFFSET    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COMPLEX_MODE = 3'd4;

  // Register reset values
  localparam logic [31:0]        FREQUENCY_RST = 32'd3276800;  // 50.0 in Q16.16
  localparam logic [15:0]        PHASE_RST     = 16'd0;
  localparam logic signed [15:0] AMPLITUDE_RST = 16'sd32767;
  localparam logic signed [15:0] DC_OFFSET_RST = 16'sd0;

  // Depth of the queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // CORDIC rotation: datapath width (Q2.30 plus headroom), gain-compensated start
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) as a 32-bit fraction of a turn
  localparam logic [31:0] ARC_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // Live configuration
  typedef struct packed {
    logic [31:0]        frequency;
    logic [15:0]        phase_turns;
    logic signed [15:0] amplitude;
    logic signed [15:0] dc_offset;
    logic               complex_mode;
  } cfg_t;

endpackage

// ----- src/sqwg_if.sv -----
// Handshake channel interfaces: sample input, result output, register writes.
`timescale 1ns / 1ps

interface sqwg_in_if import sqwg_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] time_value;

  modport source (output valid, output time_value, input ready);
  modport sink   (input valid, input time_value, output ready);
endinterface

interface sqwg_out_if import sqwg_pkg::*; #(
  parameter int OUT_WIDTH = 16
) ();
  logic                        valid;
  logic                        ready;
  logic signed [OUT_WIDTH-1:0] first_value;
  logic signed [OUT_WIDTH-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface

interface sqwg_cfg_if import sqwg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/sqwg_front.sv -----
// Front end: accepts sample times, forms the phase and folds it to the right half-plane.
`timescale 1ns / 1ps

module sqwg_front import sqwg_pkg::*; #(
  parameter int PHASE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cfg_t                cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         time_value,
  input  logic                q_full,
  output logic                q_push,
  output logic [PHASE_BITS:0] q_entry      // {flip, folded phase}
);

  logic        en;
  logic        v1_r, v2_r;
  logic [31:0] p_lo_r;
  logic [15:0] p_ab_r, p_ba_r;
  logic [31:0] phase;
  logic        flip;
  logic [PHASE_BITS:0] entry_r;

  // whole front stalls only when its last stage cannot drain into the queue
  assign en       = !(v2_r && q_full);
  assign in_ready = en;
  assign q_push   = v2_r && !q_full;
  assign q_entry  = entry_r;

  // stage 2 phase: low word of freq*time plus offset at bit 16
  always_comb begin
    phase = p_lo_r + {p_ab_r + p_ba_r + cfg.phase_turns, 16'h0000};
    flip  = phase[31] ^ phase[30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
    if (en) begin
      // partial products; only the low 32 bits of the full product matter
      p_lo_r  <= cfg.frequency[15:0] * time_value[15:0];
      p_ab_r  <= 16'(cfg.frequency[15:0] * time_value[31:16]);
      p_ba_r  <= 16'(cfg.frequency[31:16] * time_value[15:0]);
      // quantise, then rotate by half a turn into [-1/4, 1/4) when needed
      entry_r <= {flip, phase[31] ^ flip, phase[30 -: PHASE_BITS-1]};
    end
  end

endmodule

// ----- src/sqwg_queue.sv -----
// Small register queue decoupling the phase front end from the CORDIC back end.
`timescale 1ns / 1ps

module sqwg_queue #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNW-1:0]   cnt_r;

  assign full     = (cnt_r == CNW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/sqwg_back.sv -----
// Back end: pipelined CORDIC rotation, amplitude scaling, offset and saturation.
`timescale 1ns / 1ps

module sqwg_back import sqwg_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int OUT_WIDTH  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cfg_t                        cfg,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [PHASE_BITS:0]         q_entry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_WIDTH-1:0] first_value,
  output logic signed [OUT_WIDTH-1:0] second_value
);

  localparam int SAT_W = (OUT_WIDTH > 18) ? OUT_WIDTH : 18;
  localparam logic signed [SAT_W-1:0] OMAX =
    {{(SAT_W-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
  localparam logic signed [SAT_W-1:0] OMIN = ~OMAX;

  // Q2.30 to Q1.15, half-up rounding and clamp
  function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    logic signed [CW-16:0] q;
    r = v + CW'(16384);
    q = r[CW-1:15];
    if (q > 19'sd32767)       return 16'sd32767;
    else if (q < -19'sd32768) return -16'sd32768;
    else                      return q[15:0];
  endfunction

  // clamp to the output width
  function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [17:0] v);
    logic signed [SAT_W-1:0] w;
    w = SAT_W'(v);
    if (w > OMAX)      return OMAX[OUT_WIDTH-1:0];
    else if (w < OMIN) return OMIN[OUT_WIDTH-1:0];
    else               return w[OUT_WIDTH-1:0];
  endfunction

  logic en;

  logic                 vld_r  [CORDIC_STEPS+1];
  logic signed [CW-1:0] x_r    [CORDIC_STEPS+1];
  logic signed [CW-1:0] y_r    [CORDIC_STEPS+1];
  logic signed [CW-1:0] z_r    [CORDIC_STEPS+1];
  logic                 flip_r [CORDIC_STEPS+1];

  logic               rnd_vld_r, mul_vld_r, out_vld_r;
  logic signed [15:0] cos_r, sin_r;
  logic signed [31:0] pc_r, ps_r;
  logic signed [31:0] rc, rs;
  logic signed [17:0] sc, ss, sum_s;
  logic signed [OUT_WIDTH-1:0] first_r, second_r;
  logic signed [CW-1:0] xf, yf;

  // whole back end advances unless the output register holds an untaken result
  assign en           = !out_vld_r || out_ready;
  assign q_pop        = en && !q_empty;
  assign out_valid    = out_vld_r;
  assign first_value  = first_r;
  assign second_value = second_r;

  // stage 0: start vector and angle from the queue head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= !q_empty;
    end
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= {{2{q_entry[PHASE_BITS-1]}}, q_entry[PHASE_BITS-1:0],
                    {(32-PHASE_BITS){1'b0}}};
      flip_r[0] <= q_entry[PHASE_BITS];
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [CW-1:0] arc;
    assign arc = {2'b00, ARC_TURNS[i]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - arc;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + arc;
        end
      end
    end
  end

  // undo the half-turn fold, round to Q1.15
  always_comb begin
    xf = flip_r[CORDIC_STEPS] ? -x_r[CORDIC_STEPS] : x_r[CORDIC_STEPS];
    yf = flip_r[CORDIC_STEPS] ? -y_r[CORDIC_STEPS] : y_r[CORDIC_STEPS];
  end

  // scaled values, rounded back to output units
  always_comb begin
    rc    = pc_r + 32'sd16384;
    rs    = ps_r + 32'sd16384;
    sc    = {rc[31], rc[31:15]};
    ss    = {rs[31], rs[31:15]};
    sum_s = ss + 18'(cfg.dc_offset);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      rnd_vld_r <= vld_r[CORDIC_STEPS];
      mul_vld_r <= rnd_vld_r;
      out_vld_r <= mul_vld_r;
    end
    if (en) begin
      cos_r <= to_q15(xf);
      sin_r <= to_q15(yf);
      pc_r  <= cfg.amplitude * cos_r;
      ps_r  <= cfg.amplitude * sin_r;
      if (cfg.complex_mode) begin
        first_r  <= sat_out(sc);
        second_r <= sat_out(ss);
      end else begin
        first_r  <= sat_out(sum_s);
        second_r <= '0;
      end
    end
  end

endmodule

// ----- src/sine_quadrature_wave_generator.sv -----
// Top level of the quadrature sine/cosine generator: registers, front end, queue, back end.
// Path from an accepted request to its result: the phase stages, queue write,
//   CORDIC load, 16 CORDIC stages, round, multiply, output register.
// Throughput: one request per cycle unless an untaken output result stalls the pipeline.
// Reset (rst_n, synchronous, active low) empties all stages and the queue and loads
//   register defaults: frequency 50.0, phase 0, amplitude 32767, offset 0, real mode.
`timescale 1ns / 1ps

module sine_quadrature_wave_generator import sqwg_pkg::*; #(
  parameter int PHASE_BITS = 16,
  parameter int OUT_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sqwg_in_if.sink    in_if,
  sqwg_out_if.source out_if,
  sqwg_cfg_if.sink   cfg_if
);

  cfg_t cfg_r;

  logic                q_push, q_pop, q_full, q_empty;
  logic [PHASE_BITS:0] q_wdata, q_rdata;

  // register writes, always accepted
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frequency    <= FREQUENCY_RST;
      cfg_r.phase_turns  <= PHASE_RST;
      cfg_r.amplitude    <= AMPLITUDE_RST;
      cfg_r.dc_offset    <= DC_OFFSET_RST;
      cfg_r.complex_mode <= 1'b0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_FREQUENCY:    cfg_r.frequency    <= cfg_if.data;
        REG_PHASE_TURNS:  cfg_r.phase_turns  <= cfg_if.data[15:0];
        REG_AMPLITUDE:    cfg_r.amplitude    <= cfg_if.data[15:0];
        REG_DC_OFFSET:    cfg_r.dc_offset    <= cfg_if.data[15:0];
        REG_COMPLEX_MODE: cfg_r.complex_mode <= cfg_if.data[0];
        default: ;
      endcase
    end
  end

  sqwg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .time_value (in_if.time_value),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_wdata)
  );

  sqwg_queue #(
    .WIDTH(PHASE_BITS + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  sqwg_back #(
    .PHASE_BITS(PHASE_BITS),
    .OUT_WIDTH (OUT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_entry      (q_rdata),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .first_value  (out_if.first_value),
    .second_value (out_if.second_value)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the quadrature sine/cosine generator.
`timescale 1ns / 1ps

module tb_top;
  import sqwg_pkg::*;

  localparam int PHASE_BITS      = 16;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 86;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int TAIL_CYCLES     = 30;   // wait after the drain to catch stray results
  localparam int MAX_REPORTS     = 40;

  // Indexes past the register list; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [31:0] PHASE_MASK    = ~32'h0 << (32 - PHASE_BITS);
  localparam longint      CORDIC_START_X = 652032874;

  // atan(2^-i) in turns, 32-bit fraction
  localparam logic [31:0] ROT_STEP_ANGLE [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef enum logic [1:0] {ROW_CFG, ROW_PREDICT, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     idx;
    logic [31:0]              word;     // register data or sample time
    logic signed [15:0]       want_first;
    logic signed [15:0]       want_second;
  } stim_row_t;

  typedef struct {
    logic signed [15:0] first_value;
    logic signed [15:0] second_value;
  } wave_pair_t;

  // Directed requests: extremes, wrap, inversion, saturation, ignored writes
  localparam int N_DIRECTED = 34;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_PREDICT, '0, 32'h0000_0000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'hFFFF_FFFF, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0001_0000, 16'sh0, 16'sh0},   // whole turns vanish
    '{ROW_PREDICT, '0, 32'h0000_0001, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h8000_0000, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_FREQUENCY, 32'h0001_0000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_4000, 16'sh0, 16'sh0},   // quarter turn, peak
    '{ROW_PREDICT, '0, 32'h0000_C000, 16'sh0, 16'sh0},   // trough
    '{ROW_CFG, REG_DC_OFFSET, 32'h0000_7FFF, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_4000, 16'sh0, 16'sh0},   // sum saturates high
    '{ROW_CFG, REG_AMPLITUDE, 32'h7FFF_8000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_4000, 16'sh0, 16'sh0},   // inverted wave
    '{ROW_CFG, REG_DC_OFFSET, 32'h0000_8000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_4000, 16'sh0, 16'sh0},   // sum saturates low
    '{ROW_CFG, REG_AMPLITUDE, 32'h0000_0000, 16'sh0, 16'sh0},
    '{ROW_TYPED, '0, 32'h1234_5678, 16'sh8000, 16'sh0000},
    '{ROW_CFG, REG_DC_OFFSET, 32'hABCD_7FFF, 16'sh0, 16'sh0},
    '{ROW_TYPED, '0, 32'hFFFF_FFFF, 16'sh7FFF, 16'sh0000},
    '{ROW_CFG, REG_SPARE_LO, 32'h0000_0000, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_SPARE_HI, 32'hFFFF_FFFF, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_COMPLEX_MODE, 32'hFFFF_FFFE, 16'sh0, 16'sh0},
    '{ROW_TYPED, '0, 32'h0000_0000, 16'sh7FFF, 16'sh0000},
    '{ROW_CFG, REG_COMPLEX_MODE, 32'h0000_0001, 16'sh0, 16'sh0},
    '{ROW_TYPED, '0, 32'h0000_4000, 16'sh0000, 16'sh0000},
    '{ROW_CFG, REG_AMPLITUDE, 32'h0000_7FFF, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_FREQUENCY, 32'hFFFF_FFFF, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_PHASE_TURNS, 32'h0000_FFFF, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'hFFFF_FFFF, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_0000, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_PHASE_TURNS, 32'h0000_4000, 16'sh0, 16'sh0},
    '{ROW_CFG, REG_FREQUENCY, 32'h0000_0000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h5555_5555, 16'sh0, 16'sh0},   // offset only
    '{ROW_CFG, REG_AMPLITUDE, 32'h0000_8000, 16'sh0, 16'sh0},
    '{ROW_PREDICT, '0, 32'h0000_0000, 16'sh0, 16'sh0}
  };

  logic clk;
  logic rst_n;

  sqwg_in_if                   in_bus ();
  sqwg_out_if #(.OUT_WIDTH(16)) out_bus ();
  sqwg_cfg_if                  cfg_bus ();

  sine_quadrature_wave_generator #(
    .PHASE_BITS(PHASE_BITS),
    .OUT_WIDTH (16)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_bus),
    .out_if(out_bus),
    .cfg_if(cfg_bus)
  );

  cfg_t       wave_cfg;           // shadow of the register file
  wave_pair_t expected_pairs[$];  // one entry per accepted request, oldest first
  int         err_count;
  int         cycle_count;
  int         burst_left;
  int         phase_idx;
  int         item_idx;
  int         row_idx;
  logic [31:0] time_word;

  // Clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic signed [15:0] sat16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint amp_mul(input longint q15);
    return (longint'($signed(wave_cfg.amplitude)) * q15 + 16384) >>> 15;
  endfunction

  // Expected sample pair for one time value under the shadow registers
  function automatic wave_pair_t predict_wave(input logic [31:0] t);
    logic [63:0] prod;
    logic [31:0] ang;
    longint      x, y, z, dx, dy, s, c;
    bit          flip;
    int          i;
    wave_pair_t  r;
    prod = {32'h0, wave_cfg.frequency} * {32'h0, t};
    ang  = (prod[31:0] + {wave_cfg.phase_turns, 16'h0000}) & PHASE_MASK;
    // fold the left half-plane onto the right one
    flip = (ang >= 32'h4000_0000) && (ang < 32'hC000_0000);
    if (flip) ang = ang - 32'h8000_0000;
    z = longint'($signed(ang));
    x = CORDIC_START_X;
    y = 0;
    for (i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ROT_STEP_ANGLE[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ROT_STEP_ANGLE[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = sat16((y + 16384) >>> 15);
    c = sat16((x + 16384) >>> 15);
    if (wave_cfg.complex_mode) begin
      r.first_value  = sat16(amp_mul(c));
      r.second_value = sat16(amp_mul(s));
    end else begin
      r.first_value  = sat16(amp_mul(s) + longint'($signed(wave_cfg.dc_offset)));
      r.second_value = 16'sh0000;
    end
    return r;
  endfunction

  // Low extreme, high extreme, a middle value, or random; early phases are fixed
  function automatic logic [31:0] pick_word(input int phase, input logic [31:0] lo,
                                            input logic [31:0] hi, input logic [31:0] mid);
    int sel;
    sel = (phase < 4) ? phase : $urandom_range(0, 5);
    case (sel)
      0: return lo;
      1: return hi;
      2: return mid;
      default: return $urandom;
    endcase
  endfunction

  // Stop the sample stream, let the pipe drain, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    in_bus.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_FREQUENCY:    wave_cfg.frequency    = data;
      REG_PHASE_TURNS:  wave_cfg.phase_turns  = data[15:0];
      REG_AMPLITUDE:    wave_cfg.amplitude    = data[15:0];
      REG_DC_OFFSET:    wave_cfg.dc_offset    = data[15:0];
      REG_COMPLEX_MODE: wave_cfg.complex_mode = data[0];
      default: ;
    endcase
  endtask

  // One sample request, sent in bursts with random gaps between them
  task automatic send_sample(input logic [31:0] t, input bit typed,
                             input logic signed [15:0] want_first,
                             input logic signed [15:0] want_second);
    int         gap;
    wave_pair_t exp_pair;
    cfg_bus.valid <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_bus.valid      <= 1'b1;
    in_bus.time_value <= t;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (typed) begin
      exp_pair.first_value  = want_first;
      exp_pair.second_value = want_second;
    end else begin
      exp_pair = predict_wave(t);
    end
    expected_pairs.insert(expected_pairs.size(), exp_pair);
  endtask

  // Result side: check each accepted result, stall on a pattern of its own
  initial begin : result_side
    int         stall_mode;
    int         mode_left;
    wave_pair_t exp_pair;
    stall_mode = 0;
    mode_left  = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (expected_pairs.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: result with no request pending: first %0d second %0d",
                     $time, out_bus.first_value, out_bus.second_value);
        end else begin
          exp_pair = expected_pairs.pop_front();
          if (out_bus.first_value !== exp_pair.first_value ||
              out_bus.second_value !== exp_pair.second_value) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected first %0d second %0d, got first %0d second %0d",
                       $time, exp_pair.first_value, exp_pair.second_value,
                       out_bus.first_value, out_bus.second_value);
          end
        end
      end
      // stall pattern: free flow, light, heavy, periodic
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(32, 200);
      end
      mode_left--;
      case (stall_mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= ($urandom_range(0, 3) != 0);
        2: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default: out_bus.ready <= (cycle_count % 8 < 5);
      endcase
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Main sequence
  initial begin
    err_count  = 0;
    burst_left = 0;
    wave_cfg.frequency    = FREQUENCY_RST;
    wave_cfg.phase_turns  = PHASE_RST;
    wave_cfg.amplitude    = AMPLITUDE_RST;
    wave_cfg.dc_offset    = DC_OFFSET_RST;
    wave_cfg.complex_mode = 1'b0;
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.time_value <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= REG_FREQUENCY;
    cfg_bus.data      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (row_idx = 0; row_idx < N_DIRECTED; row_idx++) begin
      case (DIRECTED[row_idx].kind)
        ROW_CFG:   write_reg(DIRECTED[row_idx].idx, DIRECTED[row_idx].word);
        ROW_TYPED: send_sample(DIRECTED[row_idx].word, 1'b1,
                               DIRECTED[row_idx].want_first, DIRECTED[row_idx].want_second);
        default:   send_sample(DIRECTED[row_idx].word, 1'b0, 16'sh0, 16'sh0);
      endcase
    end

    // random phases, each under a fresh register setting
    for (phase_idx = 0; phase_idx < NUM_PHASES; phase_idx++) begin
      write_reg(REG_FREQUENCY, pick_word(phase_idx, 32'h0, 32'hFFFF_FFFF,
                                         $urandom_range(1, 32'h0010_0000)));
      if ($urandom_range(0, 1) == 1)
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
      write_reg(REG_PHASE_TURNS, {16'($urandom),
                16'(pick_word(phase_idx, 32'h0, 32'hFFFF, 32'h4000))});
      write_reg(REG_AMPLITUDE, {16'($urandom),
                16'(pick_word(phase_idx, 32'h8000, 32'h7FFF, 32'h0))});
      write_reg(REG_DC_OFFSET, {16'($urandom),
                16'(pick_word(phase_idx, 32'h8000, 32'h7FFF, 32'h0))});
      write_reg(REG_COMPLEX_MODE, {31'($urandom), phase_idx[0]});
      for (item_idx = 0; item_idx < ITEMS_PER_PHASE; item_idx++) begin
        case ($urandom_range(0, 9))
          0: time_word = 32'h0000_0000;
          1: time_word = 32'hFFFF_FFFF;
          2: time_word = $urandom_range(0, 32'h0002_0000);
          default: time_word = $urandom;
        endcase
        send_sample(time_word, 1'b0, 16'sh0, 16'sh0);
      end
    end

    // drain, then watch for stray results
    in_bus.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- files.f -----
src/sqwg_pkg.sv
src/sqwg_if.sv
src/sqwg_front.sv
src/sqwg_queue.sv
src/sqwg_back.sv
src/sine_quadrature_wave_generator.sv
tb/tb_top.sv
